// ===== hw/rtl/cbor_byte_string_decoder_core_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef CBOR_BYTE_STRING_DECODER_CORE_DEFINES_SVH
`define CBOR_BYTE_STRING_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CBD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbor_bsd: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define CBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbor_bsd: next-cycle check failed");

`endif

// ===== hw/rtl/cbor_bsd_pkg.sv =====
package cbor_bsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int LEN_W    = 64;
   localparam int LCNT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int AI_W     = 5;

   // header byte layout
   localparam int              MT_SHIFT      = 5;
   localparam logic [2:0]      MT_BYTES      = 3'd2;
   localparam logic [AI_W-1:0] AI_INDEF      = 5'h1F;
   localparam logic [AI_W-1:0] AI_DIRECT_MAX = 5'd23;
   localparam logic [AI_W-1:0] AI_LEN_LAST   = 5'd27;
   localparam logic [BYTE_W-1:0] BREAK_BYTE  = 8'hFF;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHUNK
   } phase_type;

   typedef struct packed {
      logic                data_valid;
      logic [BYTE_W-1:0]   data_byte;
      logic [WORD_W-1:0]   data_index;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   total_length;
   } result_type;

endpackage

// ===== hw/rtl/cbor_bsd_if.sv =====
interface cbor_bsd_req_if;
   logic                              valid;
   logic                              ready;
   logic [cbor_bsd_pkg::BYTE_W-1:0]   stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface cbor_bsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               data_valid;
   logic [cbor_bsd_pkg::BYTE_W-1:0]    data_byte;
   logic [cbor_bsd_pkg::WORD_W-1:0]    data_index;
   logic                               done_res;
   logic [cbor_bsd_pkg::STATUS_W-1:0]  status;
   logic [cbor_bsd_pkg::WORD_W-1:0]    total_length;

   modport source (output valid, output data_valid, output data_byte, output data_index,
                   output done_res, output status, output total_length, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input data_index,
                   input done_res, input status, input total_length, output ready);
endinterface

// ===== hw/rtl/cbor_byte_string_decoder_core.sv =====
// An accepted byte waits in the input register, its result in the result
// register. Throughput: one byte per cycle unless rsp stalls; the two item
// registers hold one each, with the state update a single pass between them.
// Reset (synchronous, active high): decoder returns to awaiting a header,
// both item registers empty, buffer_size set to all ones.
`include "cbor_byte_string_decoder_core_defines.svh"

module cbor_byte_string_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   cbor_bsd_req_if.sink                       req,
   cbor_bsd_rsp_if.source                     rsp,
   input  logic                               csr_wr_en,
   input  logic [cbor_bsd_pkg::WORD_W-1:0]    csr_wr_data
);

   localparam int BW = cbor_bsd_pkg::BYTE_W;
   localparam int WW = cbor_bsd_pkg::WORD_W;
   localparam int LW = cbor_bsd_pkg::LEN_W;
   localparam int CW = cbor_bsd_pkg::LCNT_W;

   // configuration
   logic [WW-1:0] buffer_size_ff;

   // item registers
   logic                       in_valid_ff;
   logic [BW-1:0]              in_byte_ff;
   logic                       rsp_valid_ff;
   cbor_bsd_pkg::result_type   rsp_q_ff;

   // decoder state
   cbor_bsd_pkg::phase_type phase_ff,       phase_in;
   logic                    indef_ff,       indef_in;
   logic [LW-1:0]           len_acc_ff,     len_acc_in;
   logic [CW-1:0]           len_left_ff,    len_left_in;
   logic [LW-1:0]           payload_left_ff, payload_left_in;
   logic [WW-1:0]           write_index_ff, write_index_in;

   // step results
   logic                     emit;
   cbor_bsd_pkg::result_type res;
   logic                     advance;

   // decode helpers
   logic [cbor_bsd_pkg::AI_W-1:0] ai;
   logic [2:0]                    mt;
   logic                          len_event;
   logic [LW-1:0]                 len_sel;
   logic [LW-1:0]                 acc_shift;
   logic [CW-1:0]                 len_left_dec;
   logic [LW-1:0]                 payload_dec;
   logic [WW-1:0]                 index_inc;
   logic [WW:0]                   room;
   logic                          too_big;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign ai           = in_byte_ff[cbor_bsd_pkg::AI_W-1:0];
   assign mt           = in_byte_ff[BW-1:cbor_bsd_pkg::MT_SHIFT];
   assign acc_shift    = {len_acc_ff[LW-BW-1:0], in_byte_ff};
   assign len_left_dec = len_left_ff - CW'(len_left_ff != '0);
   assign payload_dec  = payload_left_ff - LW'(payload_left_ff != '0);
   assign index_inc    = write_index_ff + WW'(1);

   // space left in the buffer for another chunk
   assign room = {1'b0, buffer_size_ff} - {1'b0, write_index_ff};

   // the mode is always clear while awaiting a header, so the stored flag serves
   always_comb begin
      if (indef_ff) begin
         too_big = room[WW] || (len_sel[LW-1:WW] != '0) || (len_sel[WW-1:0] > room[WW-1:0]);
      end else begin
         too_big = (len_sel[LW-1:WW] != '0) || (len_sel[WW-1:0] > buffer_size_ff);
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      indef_in        = indef_ff;
      len_acc_in      = len_acc_ff;
      len_left_in     = len_left_ff;
      payload_left_in = payload_left_ff;
      write_index_in  = write_index_ff;
      emit            = 1'b0;
      res             = '0;
      len_event       = 1'b0;
      len_sel         = '0;

      unique case (phase_ff)
         cbor_bsd_pkg::PH_IDLE: begin
            indef_in        = 1'b0;
            len_acc_in      = '0;
            len_left_in     = '0;
            payload_left_in = '0;
            write_index_in  = '0;
            if (mt != cbor_bsd_pkg::MT_BYTES) begin
               emit       = 1'b1;
               res.done_res = 1'b1;
               res.status = cbor_bsd_pkg::STATUS_BAD_TYPE;
            end else if (ai == cbor_bsd_pkg::AI_INDEF) begin
               indef_in = 1'b1;
               phase_in = cbor_bsd_pkg::PH_CHUNK;
            end else if (ai <= cbor_bsd_pkg::AI_DIRECT_MAX) begin
               len_event = 1'b1;
               len_sel   = LW'(ai);
            end else if (ai <= cbor_bsd_pkg::AI_LEN_LAST) begin
               len_left_in = CW'(1) << ai[1:0];
               phase_in    = cbor_bsd_pkg::PH_LEN;
            end else begin
               emit         = 1'b1;
               res.done_res = 1'b1;
               res.status   = cbor_bsd_pkg::STATUS_RESERVED;
            end
         end

         cbor_bsd_pkg::PH_CHUNK: begin
            if (in_byte_ff == cbor_bsd_pkg::BREAK_BYTE) begin
               phase_in         = cbor_bsd_pkg::PH_IDLE;
               indef_in         = 1'b0;
               len_acc_in       = '0;
               len_left_in      = '0;
               payload_left_in  = '0;
               emit             = 1'b1;
               res.done_res     = 1'b1;
               res.total_length = write_index_ff;
            end else if (ai <= cbor_bsd_pkg::AI_DIRECT_MAX) begin
               len_event = 1'b1;
               len_sel   = LW'(ai);
            end else if (ai <= cbor_bsd_pkg::AI_LEN_LAST) begin
               len_acc_in  = '0;
               len_left_in = CW'(1) << ai[1:0];
               phase_in    = cbor_bsd_pkg::PH_LEN;
            end else begin
               // reserved codes and a nested indefinite header
               phase_in        = cbor_bsd_pkg::PH_IDLE;
               indef_in        = 1'b0;
               len_acc_in      = '0;
               len_left_in     = '0;
               payload_left_in = '0;
               emit            = 1'b1;
               res.done_res    = 1'b1;
               res.status      = cbor_bsd_pkg::STATUS_RESERVED;
            end
         end

         cbor_bsd_pkg::PH_LEN: begin
            len_acc_in  = acc_shift;
            len_left_in = len_left_dec;
            if (len_left_dec == '0) begin
               len_event = 1'b1;
               len_sel   = acc_shift;
            end
         end

         cbor_bsd_pkg::PH_PAYLOAD: begin
            write_index_in  = index_inc;
            payload_left_in = payload_dec;
            emit            = 1'b1;
            res.data_valid  = 1'b1;
            res.data_byte   = in_byte_ff;
            res.data_index  = write_index_ff;
            if (payload_dec == '0) begin
               if (indef_ff) begin
                  phase_in = cbor_bsd_pkg::PH_CHUNK;
               end else begin
                  phase_in         = cbor_bsd_pkg::PH_IDLE;
                  len_acc_in       = '0;
                  len_left_in      = '0;
                  res.done_res     = 1'b1;
                  res.total_length = index_inc;
               end
            end
         end

         default: begin
            phase_in        = cbor_bsd_pkg::PH_IDLE;
            indef_in        = 1'b0;
            len_acc_in      = '0;
            len_left_in     = '0;
            payload_left_in = '0;
         end
      endcase

      // length now known: check it against the buffer, then start the payload unless it is zero
      if (len_event) begin
         if (too_big) begin
            phase_in        = cbor_bsd_pkg::PH_IDLE;
            indef_in        = 1'b0;
            len_acc_in      = '0;
            len_left_in     = '0;
            payload_left_in = '0;
            emit            = 1'b1;
            res             = '0;
            res.done_res    = 1'b1;
            res.status      = cbor_bsd_pkg::STATUS_TOO_BIG;
         end else if (len_sel == '0) begin
            if (indef_in) begin
               phase_in = cbor_bsd_pkg::PH_CHUNK;
            end else begin
               phase_in        = cbor_bsd_pkg::PH_IDLE;
               len_acc_in      = '0;
               len_left_in     = '0;
               payload_left_in = '0;
               emit            = 1'b1;
               res             = '0;
               res.done_res    = 1'b1;
            end
         end else begin
            payload_left_in = len_sel;
            phase_in        = cbor_bsd_pkg::PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= '1;
      end else if (csr_wr_en) begin
         buffer_size_ff <= csr_wr_data;
      end
   end

   // input register: hold until the step can retire
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= cbor_bsd_pkg::PH_IDLE;
         indef_ff        <= 1'b0;
         len_acc_ff      <= '0;
         len_left_ff     <= '0;
         payload_left_ff <= '0;
         write_index_ff  <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         indef_ff        <= indef_in;
         len_acc_ff      <= len_acc_in;
         len_left_ff     <= len_left_in;
         payload_left_ff <= payload_left_in;
         write_index_ff  <= write_index_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_q_ff <= res;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.data_valid   = rsp_q_ff.data_valid;
   assign rsp.data_byte    = rsp_q_ff.data_byte;
   assign rsp.data_index   = rsp_q_ff.data_index;
   assign rsp.done_res     = rsp_q_ff.done_res;
   assign rsp.status       = rsp_q_ff.status;
   assign rsp.total_length = rsp_q_ff.total_length;

   `CBD_ASSERT_SAME(a_result_kind, rsp_valid_ff, rsp_q_ff.data_valid || rsp_q_ff.done_res)
   `CBD_ASSERT_SAME(a_error_clean, rsp_valid_ff && (rsp_q_ff.status != cbor_bsd_pkg::STATUS_OK), !rsp_q_ff.data_valid && (rsp_q_ff.total_length == '0))
   `CBD_ASSERT_SAME(a_payload_left, phase_ff == cbor_bsd_pkg::PH_PAYLOAD, payload_left_ff != '0)
   `CBD_ASSERT_SAME(a_len_left, phase_ff == cbor_bsd_pkg::PH_LEN, len_left_ff != '0)
   `CBD_ASSERT_NEXT(a_stall_hold, in_valid_ff && rsp_valid_ff && !rsp.ready, in_valid_ff && $stable(in_byte_ff))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cbor_bsd_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 275;
   localparam int HOLD_AFTER    = 1300;
   localparam int HOLD_CYCLES   = 400;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;

   cbor_bsd_req_if req_bus ();
   cbor_bsd_rsp_if rsp_bus ();

   cbor_byte_string_decoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [BYTE_W-1:0] stream_bytes [$];
   logic [BYTE_W-1:0] seq_bytes [$];
   result_type        predicted_results [$];
   result_type        head_result;

   int req_idle_pct;
   int rsp_idle_pct;
   int bytes_queued   = 0;
   int bytes_accepted = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   // decoder state as the predictor sees it
   phase_type         dec_phase;
   logic              dec_indef;
   logic [LEN_W-1:0]  len_acc;
   logic [LCNT_W-1:0] len_left;
   logic [LEN_W-1:0]  pay_left;
   logic [WORD_W-1:0] wr_idx;
   logic [WORD_W-1:0] buf_size;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------- predictor ----------------

   task automatic post_result(input logic valid, input logic [BYTE_W-1:0] data,
                              input logic [WORD_W-1:0] idx, input logic done,
                              input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] total);
      result_type r;
      r.data_valid   = valid;
      r.data_byte    = data;
      r.data_index   = idx;
      r.done_res     = done;
      r.status       = st;
      r.total_length = total;
      predicted_results.push_back(r);
   endtask

   task automatic go_idle();
      dec_phase = PH_IDLE;
      dec_indef = 1'b0;
      len_acc   = '0;
      len_left  = '0;
      pay_left  = '0;
   endtask

   task automatic finish_err(input logic [STATUS_W-1:0] st);
      go_idle();
      post_result(1'b0, '0, '0, 1'b1, st, '0);
   endtask

   task automatic length_known(input logic [LEN_W-1:0] len);
      if (dec_indef && (wr_idx > buf_size || len > {32'd0, (buf_size - wr_idx)}))
         finish_err(STATUS_TOO_BIG);
      else if (!dec_indef && len > {32'd0, buf_size})
         finish_err(STATUS_TOO_BIG);
      else if (len == 0) begin
         // an empty chunk produces nothing; an empty string completes at once
         if (dec_indef)
            dec_phase = PH_CHUNK;
         else begin
            go_idle();
            post_result(1'b0, '0, '0, 1'b1, STATUS_OK, '0);
         end
      end else begin
         pay_left  = len;
         dec_phase = PH_PAYLOAD;
      end
   endtask

   task automatic start_length(input logic [AI_W-1:0] ai);
      if (ai <= AI_DIRECT_MAX)
         length_known({{(LEN_W-AI_W){1'b0}}, ai});
      else if (ai <= AI_LEN_LAST) begin
         len_left  = 4'd1 << (ai - AI_DIRECT_MAX - 5'd1);
         len_acc   = '0;
         dec_phase = PH_LEN;
      end else
         finish_err(STATUS_RESERVED);
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] idx;
      case (dec_phase)
         PH_IDLE: begin
            go_idle();
            wr_idx = '0;
            if (b[BYTE_W-1:MT_SHIFT] != MT_BYTES)
               finish_err(STATUS_BAD_TYPE);
            else if (b[AI_W-1:0] == AI_INDEF) begin
               dec_indef = 1'b1;
               dec_phase = PH_CHUNK;
            end else
               start_length(b[AI_W-1:0]);
         end
         PH_CHUNK: begin
            if (b == BREAK_BYTE) begin
               go_idle();
               post_result(1'b0, '0, '0, 1'b1, STATUS_OK, wr_idx);
            end else if (b[AI_W-1:0] == AI_INDEF)
               finish_err(STATUS_RESERVED);
            else
               start_length(b[AI_W-1:0]);
         end
         PH_LEN: begin
            len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
            if (len_left != 0)
               len_left = len_left - 1'b1;
            if (len_left == 0)
               length_known(len_acc);
         end
         PH_PAYLOAD: begin
            idx    = wr_idx;
            wr_idx = wr_idx + 1'b1;
            if (pay_left != 0)
               pay_left = pay_left - 1'b1;
            if (pay_left != 0)
               post_result(1'b1, b, idx, 1'b0, STATUS_OK, '0);
            else if (dec_indef) begin
               dec_phase = PH_CHUNK;
               post_result(1'b1, b, idx, 1'b0, STATUS_OK, '0);
            end else begin
               go_idle();
               post_result(1'b1, b, idx, 1'b1, STATUS_OK, wr_idx);
            end
         end
         default: go_idle();
      endcase
   endtask

   // ---------------- stimulus ----------------

   function automatic logic [LEN_W-1:0] oversize(input logic [LEN_W-1:0] room);
      if ($urandom_range(3) == 0)
         return {$urandom, $urandom} | 64'h1_0000_0000;
      return room + 64'd1 + $urandom_range(9);
   endfunction

   function automatic logic [AI_W-1:0] reserved_ai();
      logic [AI_W-1:0] ai;
      ai = AI_W'($urandom_range(2));
      return ai + AI_LEN_LAST + 5'd1;
   endfunction

   task automatic put_header(input logic [2:0] mt, input logic [LEN_W-1:0] len);
      int              form;
      logic [AI_W-1:0] ai;
      if (len <= AI_DIRECT_MAX && $urandom_range(3) != 0)
         seq_bytes.push_back({mt, len[AI_W-1:0]});
      else begin
         // smallest length field that holds len, then maybe a wider one
         if (len[63:32] != 0)
            form = 3;
         else if (len[31:16] != 0)
            form = 2;
         else if (len[15:8] != 0)
            form = 1;
         else
            form = 0;
         form = $urandom_range(3, form);
         ai = AI_DIRECT_MAX + 5'd1 + form[AI_W-1:0];
         seq_bytes.push_back({mt, ai});
         for (int i = (1 << form) - 1; i >= 0; i--)
            seq_bytes.push_back(len[8*i +: 8]);
      end
   endtask

   task automatic push_payload(input logic [LEN_W-1:0] count);
      logic [BYTE_W-1:0] data;
      repeat (count) begin
         data = BYTE_W'($urandom);
         seq_bytes.push_back(data);
      end
   endtask

   task automatic add_indefinite(input logic [WORD_W-1:0] cap);
      logic [LEN_W-1:0] room;
      logic [LEN_W-1:0] len;
      logic [2:0]       mt;
      int               pick;
      int               lim;
      bit               aborted;
      room    = {32'd0, cap};
      aborted = 1'b0;
      seq_bytes.push_back({MT_BYTES, AI_INDEF});
      repeat ($urandom_range(4)) begin
         if (!aborted) begin
            // chunk major type is not checked, so mix in others
            mt = 3'($urandom_range(7));
            if ($urandom_range(3) != 0)
               mt = MT_BYTES;
            pick = $urandom_range(99);
            if (pick < 4) begin
               if ({mt, AI_INDEF} == BREAK_BYTE)
                  mt = MT_BYTES;
               seq_bytes.push_back({mt, AI_INDEF});
               aborted = 1'b1;
            end else if (pick < 8) begin
               seq_bytes.push_back({mt, reserved_ai()});
               aborted = 1'b1;
            end else if (pick < 13) begin
               put_header(mt, oversize(room));
               aborted = 1'b1;
            end else begin
               lim = (room < 64'd12) ? int'(room[WORD_W-1:0]) : 12;
               len = LEN_W'($urandom_range(lim));
               put_header(mt, len);
               push_payload(len);
               room = room - len;
            end
         end
      end
      if (!aborted)
         seq_bytes.push_back(BREAK_BYTE);
   endtask

   task automatic flush_seq();
      while (seq_bytes.size() != 0) begin
         stream_bytes.push_back(seq_bytes.pop_front());
         bytes_queued++;
      end
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (stream_bytes.size() != 0 || req_bus.valid || predicted_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_buffer_size(input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input int req_pct, input int rsp_pct,
                            input logic [WORD_W-1:0] cap, input bit wild);
      int                stop_at;
      int                pick;
      int                lim;
      int                cut;
      logic [2:0]        mt;
      logic [AI_W-1:0]   ai;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] noise;
      write_buffer_size(cap);
      @(negedge clock);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      stop_at      = bytes_queued + PHASE_BYTES;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(99);
         if (wild && pick < 5) begin
            noise = BYTE_W'($urandom);
            seq_bytes.push_back(noise);
         end else if (pick < 10) begin
            mt = 3'($urandom_range(6));
            if (mt >= MT_BYTES)
               mt = mt + 3'd1;
            ai = AI_W'($urandom_range(31));
            seq_bytes.push_back({mt, ai});
         end else if (pick < 14)
            seq_bytes.push_back({MT_BYTES, reserved_ai()});
         else if (pick < 58) begin
            if ($urandom_range(9) == 0)
               put_header(MT_BYTES, oversize({32'd0, cap}));
            else begin
               lim = (cap < 40) ? cap : 40;
               len = LEN_W'($urandom_range(lim));
               put_header(MT_BYTES, len);
               push_payload(len);
            end
         end else
            add_indefinite(cap);
         // cut the string short now and then
         if (wild && seq_bytes.size() > 1 && $urandom_range(99) < 5) begin
            cut = $urandom_range(seq_bytes.size() - 1, 1);
            repeat (cut) seq_bytes.delete(seq_bytes.size() - 1);
         end
         flush_seq();
      end
      drain();
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.stream_byte   = '0;
      rsp_bus.ready         = 1'b0;
      req_idle_pct          = 6;
      rsp_idle_pct          = 86;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full-size buffer: field extremes, short and long length fields, chunks
      write_buffer_size('1);
      @(negedge clock);
      seq_bytes = '{8'h40, 8'h00, 8'hFF, 8'h5C, 8'h58, 8'h01, 8'hAA, 8'h59, 8'h00, 8'h00,
                    8'h5B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h5F, 8'h61, 8'h55, 8'h40, 8'hFF, 8'h5F, 8'h5F};
      flush_seq();
      drain();

      // empty buffer: only zero-length strings fit
      write_buffer_size('0);
      @(negedge clock);
      seq_bytes = '{8'h41, 8'h5F, 8'h40, 8'hFF, 8'h5F, 8'h41};
      flush_seq();
      drain();

      // full-size buffer stays well formed so no length runs away
      run_phase(6, 86, '1, 1'b0);
      run_phase(6, 86, 32'd16, 1'b1);
      run_phase(86, 6, $urandom_range(48), 1'b1);
      run_phase(86, 6, $urandom_range(48), 1'b1);
      run_phase(0, 0, $urandom_range(48), 1'b1);
      run_phase(0, 0, 32'd40, 1'b1);

      if (mismatch_count == 0)
         $display("cbor_byte_string_decoder_core test passed");
      else
         $display("cbor_byte_string_decoder_core test failed");
      $finish;
   end

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset)
         req_bus.valid <= 1'b0;
      else if (!req_bus.valid || req_bus.ready) begin
         if (stream_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_bus.valid       <= 1'b1;
            req_bus.stream_byte <= stream_bytes.pop_front();
         end else
            req_bus.valid <= 1'b0;
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // ---------------- monitor ----------------

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         go_idle();
         wr_idx         = '0;
         buf_size       = '1;
         bytes_accepted <= 0;
      end else begin
         // compare first so an item accepted this edge cannot match itself
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result expected none, got byte %0h index %0h done %0b status %0d",
                        $time, rsp_bus.data_byte, rsp_bus.data_index, rsp_bus.done_res,
                        rsp_bus.status);
               mismatch_count++;
            end else begin
               head_result = predicted_results.pop_front();
               check_field("data_valid", WORD_W'(head_result.data_valid),
                           WORD_W'(rsp_bus.data_valid));
               check_field("data_byte", WORD_W'(head_result.data_byte),
                           WORD_W'(rsp_bus.data_byte));
               check_field("data_index", head_result.data_index, rsp_bus.data_index);
               check_field("done_res", WORD_W'(head_result.done_res),
                           WORD_W'(rsp_bus.done_res));
               check_field("status", WORD_W'(head_result.status), WORD_W'(rsp_bus.status));
               check_field("total_length", head_result.total_length, rsp_bus.total_length);
            end
         end
         if (csr_wr_en)
            buf_size = csr_wr_data;
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.stream_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles == STALL_LIMIT) begin
         $display("cbor_byte_string_decoder_core test failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
